>>> sv/wpid_pkg.sv
// Shared types and constants of the windowed PID controller.
// Depends on nothing; wpid_calc and windowed_pid_controller import it.
package wpid_pkg;

    localparam int WINDOW     = 16;
    localparam int HEAD_W     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int ERR_W      = 16;
    localparam int GAIN_W     = 16;
    localparam int OUT_W      = 16;
    localparam int SUM_W      = ERR_W + HEAD_W;
    localparam int DIFF_W     = ERR_W + 1;
    localparam int P_W        = GAIN_W + ERR_W;
    localparam int I_W        = GAIN_W + SUM_W;
    localparam int D_W        = GAIN_W + DIFF_W;
    localparam int IX_W       = I_W + 4;
    localparam int TOT_W      = I_W + 2;
    localparam int LIM_SHIFT  = 12;
    localparam int FX_SHIFT   = 20;
    localparam int SAT_W      = FX_SHIFT + 1;
    localparam int ROUND_BITS = 5;
    localparam int TENTH_FX   = 104858;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic signed [ERR_W-1:0] MIN_LIMIT_RST = -16'sd2560;
    localparam logic signed [ERR_W-1:0] MAX_LIMIT_RST = 16'sd2560;

    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_FLUSH  = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP_GAIN   = 3'd0,
        CFG_KI_GAIN   = 3'd1,
        CFG_KD_GAIN   = 3'd2,
        CFG_MIN_LIMIT = 3'd3,
        CFG_MAX_LIMIT = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
        logic signed [ERR_W-1:0]  min_limit;
        logic signed [ERR_W-1:0]  max_limit;
    } cfg_t;

    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [SUM_W-1:0]  sum;
        logic signed [DIFF_W-1:0] diff;
    } calc_in_t;

endpackage

>>> sv/wpid_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing.
module wpid_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                           wr_data,
    input  logic                                       rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                           rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/wpid_calc.sv
// Arithmetic pipeline of the windowed PID controller: gain products, integral bound,
// sum, saturation and rounding, with a valid/ready handshake on both sides.
// Depends on wpid_pkg.
module wpid_calc (
    input  logic                  clk,
    input  logic                  rst_n,
    input  wpid_pkg::cfg_t        cfg,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  wpid_pkg::calc_in_t    in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [wpid_pkg::OUT_W-1:0] drive
);
    import wpid_pkg::*;

    localparam logic signed [I_W-1:0]   TENTH_POS = I_W'(TENTH_FX);
    localparam logic signed [I_W-1:0]   TENTH_NEG = -I_W'(TENTH_FX);
    localparam logic signed [TOT_W-1:0] ONE_FX    = TOT_W'(1 << FX_SHIFT);
    localparam logic [SAT_W:0]          RND_HALF  = (SAT_W + 1)'(1 << (ROUND_BITS - 1));

    logic s2_valid_reg, s3_valid_reg, s4_valid_reg, s5_valid_reg, out_valid_reg;
    logic s2_valid_next, s3_valid_next, s4_valid_next, s5_valid_next, out_valid_next;
    logic go_out, s5_open, s4_open, s3_open, s2_open;

    calc_in_t                 s2_reg;
    logic signed [P_W-1:0]    s3_p_reg, s4_p_reg;
    logic signed [I_W-1:0]    s3_i_reg, s4_i_reg;
    logic signed [D_W-1:0]    s3_d_reg, s4_d_reg;
    logic signed [TOT_W-1:0]  s5_total_reg;
    logic [OUT_W-1:0]         drive_reg;

    logic signed [P_W-1:0]    p_prod;
    logic signed [I_W-1:0]    i_prod;
    logic signed [D_W-1:0]    d_prod;
    logic signed [IX_W-1:0]   i_ext, i_x10, hi_lim, lo_lim;
    logic signed [I_W-1:0]    i_bounded;
    logic signed [TOT_W-1:0]  total_sum;
    logic [SAT_W-1:0]         sat_val;
    logic [SAT_W:0]           rounded;

    assign go_out   = !out_valid_reg || out_ready;
    assign s5_open  = !s5_valid_reg || go_out;
    assign s4_open  = !s4_valid_reg || s5_open;
    assign s3_open  = !s3_valid_reg || s4_open;
    assign s2_open  = !s2_valid_reg || s3_open;
    assign in_ready = s2_open;

    assign s2_valid_next  = s2_open ? in_valid : s2_valid_reg;
    assign s3_valid_next  = s3_open ? s2_valid_reg : s3_valid_reg;
    assign s4_valid_next  = s4_open ? s3_valid_reg : s4_valid_reg;
    assign s5_valid_next  = s5_open ? s4_valid_reg : s5_valid_reg;
    assign out_valid_next = go_out ? s5_valid_reg : out_valid_reg;

    assign p_prod = cfg.kp * s2_reg.err;
    assign i_prod = cfg.ki * s2_reg.sum;
    assign d_prod = cfg.kd * s2_reg.diff;

    always_comb
    begin
        i_ext  = IX_W'(s3_i_reg);
        i_x10  = (i_ext <<< 3) + (i_ext <<< 1);
        hi_lim = IX_W'($signed({cfg.max_limit, {LIM_SHIFT{1'b0}}}));
        lo_lim = IX_W'($signed({cfg.min_limit, {LIM_SHIFT{1'b0}}}));
        if (i_x10 > hi_lim)
        begin
            i_bounded = TENTH_POS;
        end
        else if (i_x10 < lo_lim)
        begin
            i_bounded = TENTH_NEG;
        end
        else
        begin
            i_bounded = s3_i_reg;
        end
    end

    assign total_sum = TOT_W'(s4_p_reg) + TOT_W'(s4_i_reg) + TOT_W'(s4_d_reg);

    always_comb
    begin
        if (s5_total_reg > ONE_FX)
        begin
            sat_val = SAT_W'(ONE_FX);
        end
        else if (s5_total_reg < 0)
        begin
            sat_val = '0;
        end
        else
        begin
            sat_val = SAT_W'(s5_total_reg);
        end
        rounded = (SAT_W + 1)'(sat_val) + RND_HALF;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            s5_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            s4_valid_reg  <= s4_valid_next;
            s5_valid_reg  <= s5_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_open)
        begin
            s2_reg <= in_data;
        end
        if (s3_open)
        begin
            s3_p_reg <= p_prod;
            s3_i_reg <= i_prod;
            s3_d_reg <= d_prod;
        end
        if (s4_open)
        begin
            s4_p_reg <= s3_p_reg;
            s4_i_reg <= i_bounded;
            s4_d_reg <= s3_d_reg;
        end
        if (s5_open)
        begin
            s5_total_reg <= total_sum;
        end
        if (go_out)
        begin
            drive_reg <= OUT_W'(rounded >> ROUND_BITS);
        end
    end

    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

endmodule

>>> sv/windowed_pid_controller.sv
// Top level of the windowed PID controller: configuration registers, error window
// in RAM with running sum, and the arithmetic pipeline. Depends on wpid_pkg,
// wpid_ram and wpid_calc.
//
// The block takes one item per clock cycle while in_ready is high. An update
// transfer reads the oldest window sample from the RAM's registered read port;
// the running sum and previous error are updated when that sample leaves the
// read stage, and the result passes through three multipliers, the integral
// bound, the final add and the saturating round to the output. A flush clears
// the window through per-entry valid bits and gives no result. The user must
// write configuration only while no update is in flight; this is not enforced.
module windowed_pid_controller (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [wpid_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wpid_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              req_type,
    input  logic signed [wpid_pkg::ERR_W-1:0] error_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [wpid_pkg::OUT_W-1:0]        drive_out
);
    import wpid_pkg::*;

    cfg_t                    cfg_reg, cfg_next;
    logic [HEAD_W-1:0]       head_reg, head_next;
    logic [WINDOW-1:0]       live_reg, live_next;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic signed [ERR_W-1:0] prev_reg, prev_next;
    logic                    s1_valid_reg, s1_valid_next;

    logic [HEAD_W-1:0]       s1_addr_reg;
    logic signed [ERR_W-1:0] s1_err_reg;
    logic                    s1_live_reg;
    logic                    s1_fwd_reg;
    logic signed [ERR_W-1:0] s1_fwd_err_reg;

    logic                    accept, upd_accept, flush_accept;
    logic                    s1_open, s1_fire, calc_ready;
    logic [ERR_W-1:0]        ram_rdata;
    logic signed [ERR_W-1:0] old_err;
    logic signed [SUM_W-1:0] new_sum;
    logic signed [DIFF_W-1:0] diff;
    calc_in_t                calc_in;

    assign s1_fire      = s1_valid_reg && calc_ready;
    assign s1_open      = !s1_valid_reg || calc_ready;
    assign in_ready     = s1_open;
    assign accept       = in_valid && in_ready;
    assign upd_accept   = accept && (req_type == REQ_UPDATE);
    assign flush_accept = accept && (req_type == REQ_FLUSH);

    wpid_ram #(
        .WIDTH (ERR_W),
        .DEPTH (WINDOW)
    ) u_window (
        .clk     (clk),
        .wr_en   (s1_fire),
        .wr_addr (s1_addr_reg),
        .wr_data (s1_err_reg),
        .rd_en   (upd_accept),
        .rd_addr (head_reg),
        .rd_data (ram_rdata)
    );

    always_comb
    begin
        if (s1_fwd_reg)
        begin
            old_err = s1_fwd_err_reg;
        end
        else if (s1_live_reg)
        begin
            old_err = $signed(ram_rdata);
        end
        else
        begin
            old_err = '0;
        end
        new_sum = sum_reg - SUM_W'(old_err) + SUM_W'(s1_err_reg);
        diff    = DIFF_W'(s1_err_reg) - DIFF_W'(prev_reg);
        calc_in.err  = s1_err_reg;
        calc_in.sum  = new_sum;
        calc_in.diff = diff;
    end

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_KP_GAIN:   cfg_next.kp        = $signed(cfg_data);
                CFG_KI_GAIN:   cfg_next.ki        = $signed(cfg_data);
                CFG_KD_GAIN:   cfg_next.kd        = $signed(cfg_data);
                CFG_MIN_LIMIT: cfg_next.min_limit = $signed(cfg_data);
                CFG_MAX_LIMIT: cfg_next.max_limit = $signed(cfg_data);
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        head_next     = head_reg;
        live_next     = live_reg;
        sum_next      = sum_reg;
        prev_next     = prev_reg;
        s1_valid_next = s1_open ? upd_accept : s1_valid_reg;
        if (s1_fire)
        begin
            live_next[s1_addr_reg] = 1'b1;
            sum_next               = new_sum;
            prev_next              = s1_err_reg;
        end
        if (upd_accept)
        begin
            if (head_reg == HEAD_W'(WINDOW - 1))
            begin
                head_next = '0;
            end
            else
            begin
                head_next = head_reg + HEAD_W'(1);
            end
        end
        if (flush_accept)
        begin
            head_next = '0;
            live_next = '0;
            sum_next  = '0;
            prev_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp        <= '0;
            cfg_reg.ki        <= '0;
            cfg_reg.kd        <= '0;
            cfg_reg.min_limit <= MIN_LIMIT_RST;
            cfg_reg.max_limit <= MAX_LIMIT_RST;
            head_reg          <= '0;
            live_reg          <= '0;
            sum_reg           <= '0;
            prev_reg          <= '0;
            s1_valid_reg      <= 1'b0;
        end
        else
        begin
            cfg_reg      <= cfg_next;
            head_reg     <= head_next;
            live_reg     <= live_next;
            sum_reg      <= sum_next;
            prev_reg     <= prev_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd_accept)
        begin
            s1_addr_reg    <= head_reg;
            s1_err_reg     <= error_in;
            s1_live_reg    <= live_reg[head_reg];
            s1_fwd_reg     <= s1_fire && (s1_addr_reg == head_reg);
            s1_fwd_err_reg <= s1_err_reg;
        end
    end

    wpid_calc u_calc (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (s1_valid_reg),
        .in_ready  (calc_ready),
        .in_data   (calc_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .drive     (drive_out)
    );

endmodule
